// ----- hw/rtl/fr_pkg.sv -----
// Shared types and constants for the fraction reducer.
package fr_pkg;

   // Depth of the queue between the front and the back end.
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_BITS   = 1;
   localparam int QUEUE_COUNT_BITS = 2;

   // Fill status that the queue reports to both of its neighbors.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_GCD,
      BK_DIV,
      BK_EMIT
   } back_state_type;

endpackage

// ----- hw/rtl/fr_front.sv -----
// Front end: takes request beats and splits them into magnitudes and sign.
module fr_front #(
   parameter int WORD_BITS = 32
) (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [WORD_BITS-1:0]  req_numerator_in,
   input  logic signed [WORD_BITS-1:0]  req_denominator_in,
   input  fr_pkg::queue_status_type     q_status,
   output logic                         q_push,
   output logic [2*WORD_BITS+1:0]       q_push_data
);

   logic [WORD_BITS-1:0] num_raw;
   logic [WORD_BITS-1:0] den_raw;
   logic [WORD_BITS-1:0] num_mag;
   logic [WORD_BITS-1:0] den_mag;
   logic                 sign_flip;
   logic                 den_zero;

   // Two's complement magnitudes; the most negative value maps onto the top bit.
   always_comb begin
      num_raw   = $unsigned(req_numerator_in);
      den_raw   = $unsigned(req_denominator_in);
      num_mag   = num_raw[WORD_BITS-1] ? (~num_raw + 1'b1) : num_raw;
      den_mag   = den_raw[WORD_BITS-1] ? (~den_raw + 1'b1) : den_raw;
      sign_flip = num_raw[WORD_BITS-1] ^ den_raw[WORD_BITS-1];
      den_zero  = (den_raw == '0);
   end

   // A beat moves straight into the queue whenever there is room.
   assign req_stall   = q_status.full;
   assign q_push      = req_valid && !q_status.full;
   assign q_push_data = {num_mag, den_mag, sign_flip, den_zero};

endmodule

// ----- hw/rtl/fr_queue.sv -----
// Short queue of classified items between the front and the back end.
module fr_queue #(
   parameter int ENTRY_BITS = 66
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [ENTRY_BITS-1:0]      push_data,
   input  logic                       pop,
   output logic [ENTRY_BITS-1:0]      pop_data,
   output fr_pkg::queue_status_type   status
);

   logic [ENTRY_BITS-1:0]               entry_ff [fr_pkg::QUEUE_DEPTH];
   logic [fr_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff;
   logic [fr_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_in;
   logic [fr_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_ff;
   logic [fr_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_in;
   logic [fr_pkg::QUEUE_COUNT_BITS-1:0] count_ff;
   logic [fr_pkg::QUEUE_COUNT_BITS-1:0] count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + fr_pkg::QUEUE_COUNT_BITS'(push)
                           - fr_pkg::QUEUE_COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == fr_pkg::QUEUE_COUNT_BITS'(fr_pkg::QUEUE_DEPTH));

endmodule

// ----- hw/rtl/fr_back.sv -----
// Back end: binary GCD, two restoring divisions and the result register.
module fr_back #(
   parameter int WORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fr_pkg::queue_status_type     q_status,
   input  logic [2*WORD_BITS+1:0]       q_pop_data,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [WORD_BITS-1:0]  rsp_numerator_out,
   output logic [WORD_BITS-2:0]         rsp_denominator_out,
   output logic                         rsp_zero_denominator
);

   localparam int CNT_BITS = $clog2(WORD_BITS);
   localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};

   fr_pkg::back_state_type state_ff, state_in;

   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;
   logic [WORD_BITS-1:0] g_ff, g_in;
   logic [CNT_BITS-1:0]  k_ff, k_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] nq_ff, nq_in;
   logic [WORD_BITS-1:0] dq_ff, dq_in;
   logic [WORD_BITS-1:0] nrem_ff, nrem_in;
   logic [WORD_BITS-1:0] drem_ff, drem_in;
   logic                 sign_ff, sign_in;
   logic                 zero_ff, zero_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_num_ff, rsp_num_in;
   logic [WORD_BITS-2:0] rsp_den_ff, rsp_den_in;
   logic                 rsp_zero_ff, rsp_zero_in;

   logic [WORD_BITS-1:0] q_num_mag;
   logic [WORD_BITS-1:0] q_den_mag;
   logic                 q_sign;
   logic                 q_zero;
   logic [WORD_BITS-1:0] n_trial;
   logic [WORD_BITS-1:0] d_trial;
   logic                 n_fit;
   logic                 d_fit;
   logic                 out_free;
   logic                 result_neg;
   logic [WORD_BITS-1:0] emit_num;
   logic [WORD_BITS-2:0] emit_den;

   assign {q_num_mag, q_den_mag, q_sign, q_zero} = q_pop_data;

   // One restoring division step for each quotient; both share the divisor.
   always_comb begin
      n_trial = {nrem_ff[WORD_BITS-2:0], nq_ff[WORD_BITS-1]};
      d_trial = {drem_ff[WORD_BITS-2:0], dq_ff[WORD_BITS-1]};
      n_fit   = (n_trial >= g_ff);
      d_fit   = (d_trial >= g_ff);
   end

   // Sign placement and saturation of the finished quotients.
   always_comb begin
      result_neg = (nq_ff != '0) && sign_ff;
      if (zero_ff) begin
         emit_num = '0;
         emit_den = '0;
      end else begin
         if (result_neg) begin
            emit_num = ~nq_ff + 1'b1;
         end else if (nq_ff[WORD_BITS-1]) begin
            emit_num = MAX_POS;
         end else begin
            emit_num = nq_ff;
         end
         emit_den = dq_ff[WORD_BITS-1] ? MAX_POS[WORD_BITS-2:0] : dq_ff[WORD_BITS-2:0];
      end
   end

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      g_in         = g_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      nq_in        = nq_ff;
      dq_in        = dq_ff;
      nrem_in      = nrem_ff;
      drem_in      = drem_ff;
      sign_in      = sign_ff;
      zero_in      = zero_ff;
      q_pop        = 1'b0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_zero_in  = rsp_zero_ff;

      case (state_ff)
         fr_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               a_in     = q_num_mag;
               b_in     = q_den_mag;
               nq_in    = q_num_mag;
               dq_in    = q_den_mag;
               sign_in  = q_sign;
               zero_in  = q_zero;
               k_in     = '0;
               state_in = q_zero ? fr_pkg::BK_EMIT : fr_pkg::BK_GCD;
            end
         end

         // Binary GCD; b never reaches zero, so the divisor ends as b times 2^k.
         fr_pkg::BK_GCD: begin
            if (a_ff == '0) begin
               g_in     = b_ff << k_ff;
               nrem_in  = '0;
               drem_in  = '0;
               cnt_in   = '0;
               state_in = fr_pkg::BK_DIV;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff >= b_ff) begin
               a_in = (a_ff - b_ff) >> 1;
            end else begin
               b_in = (b_ff - a_ff) >> 1;
            end
         end

         fr_pkg::BK_DIV: begin
            nrem_in = n_fit ? n_trial - g_ff : n_trial;
            drem_in = d_fit ? d_trial - g_ff : d_trial;
            nq_in   = {nq_ff[WORD_BITS-2:0], n_fit};
            dq_in   = {dq_ff[WORD_BITS-2:0], d_fit};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(WORD_BITS - 1)) begin
               state_in = fr_pkg::BK_EMIT;
            end
         end

         fr_pkg::BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = emit_num;
               rsp_den_in   = emit_den;
               rsp_zero_in  = zero_ff;
               state_in     = fr_pkg::BK_IDLE;
            end
         end

         default: begin
            state_in = fr_pkg::BK_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fr_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and result payload registers.
   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      g_ff        <= g_in;
      k_ff        <= k_in;
      cnt_ff      <= cnt_in;
      nq_ff       <= nq_in;
      dq_ff       <= dq_in;
      nrem_ff     <= nrem_in;
      drem_ff     <= drem_in;
      sign_ff     <= sign_in;
      zero_ff     <= zero_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_den_ff  <= rsp_den_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_numerator_out    = $signed(rsp_num_ff);
   assign rsp_denominator_out  = rsp_den_ff;
   assign rsp_zero_denominator = rsp_zero_ff;

endmodule

// ----- hw/rtl/fraction_reducer.sv -----
// Top level of the fraction reducer: front end, queue and back end.
//
//  channel | direction | handshake          | beat contents
//  req     | in        | req_valid/req_stall | numerator_in, denominator_in
//  rsp     | out       | rsp_valid/rsp_stall | numerator_out, denominator_out,
//          |           |                     | zero_denominator
//
// Each beat takes the GCD loop (one step a cycle, at most about 2*WORD_BITS
// steps) plus WORD_BITS division steps plus the hand-off through the idle and
// emit states and the result register. A zero denominator skips both loops.
// The back end works on one item at a time; the two-entry queue keeps taking
// beats while it runs or while a result waits under rsp_stall.
// Reset is synchronous and active high and empties the queue and the result.
module fraction_reducer #(
   parameter int WORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [WORD_BITS-1:0]  req_numerator_in,
   input  logic signed [WORD_BITS-1:0]  req_denominator_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [WORD_BITS-1:0]  rsp_numerator_out,
   output logic [WORD_BITS-2:0]         rsp_denominator_out,
   output logic                         rsp_zero_denominator
);

   localparam int ENTRY_BITS = 2 * WORD_BITS + 2;

   fr_pkg::queue_status_type q_status;
   logic                     q_push;
   logic [ENTRY_BITS-1:0]    q_push_data;
   logic                     q_pop;
   logic [ENTRY_BITS-1:0]    q_pop_data;

   fr_front #(
      .WORD_BITS (WORD_BITS)
   ) u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_numerator_in   (req_numerator_in),
      .req_denominator_in (req_denominator_in),
      .q_status           (q_status),
      .q_push             (q_push),
      .q_push_data        (q_push_data)
   );

   fr_queue #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   fr_back #(
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_status             (q_status),
      .q_pop_data           (q_pop_data),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_numerator_out    (rsp_numerator_out),
      .rsp_denominator_out  (rsp_denominator_out),
      .rsp_zero_denominator (rsp_zero_denominator)
   );

endmodule

// ----- hw/rtl/fr_checker.sv -----
// Port-level checks for the fraction reducer and the bind that attaches them.
module fr_checker #(
   parameter int WORD_BITS = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [WORD_BITS-1:0]  rsp_numerator_out,
   input logic [WORD_BITS-2:0]         rsp_denominator_out,
   input logic                         rsp_zero_denominator
);

   // A stalled result beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A zero denominator comes back with both fields cleared.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_denominator |->
         rsp_numerator_out == '0 && rsp_denominator_out == '0)
      else $error("error beat carries nonzero fields");

   // A valid fraction always has a positive denominator.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_denominator |-> rsp_denominator_out != '0)
      else $error("reduced denominator is zero");

   // Zero reduces to 0/1.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_denominator && rsp_numerator_out == '0 |->
         rsp_denominator_out == (WORD_BITS-1)'(1))
      else $error("zero numerator not reduced to 0/1");

endmodule

bind fraction_reducer fr_checker #(
   .WORD_BITS (WORD_BITS)
) u_fr_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_numerator_out    (rsp_numerator_out),
   .rsp_denominator_out  (rsp_denominator_out),
   .rsp_zero_denominator (rsp_zero_denominator)
);

// ----- dv/fraction_reducer_test.sv -----
// Self-checking testbench for the fraction reducer: lowest terms and sign handling.
`timescale 1ns / 100ps

module fraction_reducer_test;

   localparam int WORD_BITS = 32;
   localparam logic [WORD_BITS-1:0] MOST_POS = 32'h7fff_ffff;
   localparam logic [WORD_BITS-1:0] MOST_NEG = 32'h8000_0000;
   localparam int RANDOM_ITEMS = 626;
   localparam int LONG_HOLD = 800;
   localparam int CYCLE_LIMIT = 1000000;

   // One reduced fraction as the block returns it.
   typedef struct packed {
      logic signed [WORD_BITS-1:0] num;
      logic [WORD_BITS-2:0]        den;
      logic                        zero_den;
   } lowest_terms_type;

   // Computes the lowest-terms form of num/den with the sign on the numerator.
   function automatic lowest_terms_type reduce_fraction(logic [WORD_BITS-1:0] num,
                                                        logic [WORD_BITS-1:0] den);
      longint unsigned num_mag, den_mag, a, b, r, num_red, den_red;
      logic [WORD_BITS-1:0] num_abs, den_abs;
      bit negative;
      lowest_terms_type res;
      num_abs = num[WORD_BITS-1] ? (~num + 1'b1) : num;
      den_abs = den[WORD_BITS-1] ? (~den + 1'b1) : den;
      num_mag = longint'(num_abs);
      den_mag = longint'(den_abs);
      res = '0;
      if (den_mag == 0) begin
         res.zero_den = 1'b1;
         return res;
      end
      // Euclid's algorithm on the magnitudes; the divisor is nonzero here.
      a = num_mag;
      b = den_mag;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      num_red = num_mag / a;
      den_red = den_mag / a;
      negative = (num_red != 0) && (num[WORD_BITS-1] != den[WORD_BITS-1]);
      // Results that overflow their field saturate, except a negative 2^31.
      if (den_red > longint'(MOST_POS)) den_red = longint'(MOST_POS);
      if (negative) begin
         res.num = -num_red[WORD_BITS-1:0];
      end else if (num_red > longint'(MOST_POS)) begin
         res.num = MOST_POS;
      end else begin
         res.num = num_red[WORD_BITS-1:0];
      end
      res.den = den_red[WORD_BITS-2:0];
      return res;
   endfunction

   // Holds the reduced fractions still owed by the block, in order.
   class lowest_terms_board;
      lowest_terms_type owed_fractions[$];
      int failures = 0;

      function void note_fraction(logic [WORD_BITS-1:0] num, logic [WORD_BITS-1:0] den);
         owed_fractions.push_back(reduce_fraction(num, den));
      endfunction

      function void check_reduced(logic signed [WORD_BITS-1:0] num,
                                  logic [WORD_BITS-2:0] den, logic zero_den);
         lowest_terms_type want;
         if (owed_fractions.size() == 0) begin
            $display("%0t: unexpected result beat %0d/%0d zero_denominator=%0b",
                     $time, num, den, zero_den);
            failures++;
            return;
         end
         want = owed_fractions.pop_front();
         if (num !== want.num) begin
            $display("%0t: numerator_out expected %0d, got %0d", $time, want.num, num);
            failures++;
         end
         if (den !== want.den) begin
            $display("%0t: denominator_out expected %0d, got %0d", $time, want.den, den);
            failures++;
         end
         if (zero_den !== want.zero_den) begin
            $display("%0t: zero_denominator expected %0b, got %0b",
                     $time, want.zero_den, zero_den);
            failures++;
         end
      endfunction

      function int outstanding();
         return owed_fractions.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [WORD_BITS-1:0] req_numerator_in = '0;
   logic signed [WORD_BITS-1:0] req_denominator_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [WORD_BITS-1:0] rsp_numerator_out;
   logic [WORD_BITS-2:0] rsp_denominator_out;
   logic rsp_zero_denominator;

   lowest_terms_board board = new();
   bit steady_tail = 1'b0;
   bit long_hold_req = 1'b0;
   int cycle_count = 0;

   fraction_reducer #(.WORD_BITS(WORD_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_numerator_in(req_numerator_in),
      .req_denominator_in(req_denominator_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_numerator_out(rsp_numerator_out),
      .rsp_denominator_out(rsp_denominator_out),
      .rsp_zero_denominator(rsp_zero_denominator)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fraction_reducer regression: fail");
         $finish;
      end
   end

   // Check every result beat taken from the block.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_reduced(rsp_numerator_out, rsp_denominator_out, rsp_zero_denominator);
      end
   end

   // Receiver pacing: random stall bursts, plus one long hold-off on request.
   initial begin : sink_pacing
      int span;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!reset && !steady_tail && $urandom_range(0, 4) == 0) begin
            span = $urandom_range(1, 6);
            rsp_stall <= 1'b1;
            repeat (span) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one fraction, hold it until accepted, then maybe leave a gap.
   task automatic send_fraction(logic signed [WORD_BITS-1:0] num,
                                logic signed [WORD_BITS-1:0] den);
      int gap;
      req_valid <= 1'b1;
      req_numerator_in <= num;
      req_denominator_in <= den;
      do @(posedge clock); while (req_stall);
      board.note_fraction(num, den);
      if (!steady_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   function automatic logic [WORD_BITS-1:0] corner_value(int idx);
      case (idx)
         0: return '0;
         1: return 32'd1;
         2: return '1;
         3: return MOST_POS;
         4: return MOST_NEG + 1'b1;
         default: return MOST_NEG;
      endcase
   endfunction

   // Draw a random fraction from a mix of shapes.
   task automatic pick_fraction(output logic [WORD_BITS-1:0] num,
                                output logic [WORD_BITS-1:0] den);
      int shape, kbits;
      logic [WORD_BITS-1:0] factor, span, a, b;
      shape = $urandom_range(0, 99);
      if (shape < 30) begin
         num = $urandom;
         den = $urandom;
      end else if (shape < 75) begin
         // Shared factor so that the reduction has real work to do.
         kbits = $urandom_range(0, 16);
         factor = $urandom_range(1, 1 << kbits);
         span = (32'd1 << (30 - kbits)) - 1;
         a = $urandom & span;
         b = $urandom_range(1, span);
         num = a * factor;
         den = b * factor;
         if ($urandom_range(0, 1)) num = -num;
         if ($urandom_range(0, 1)) den = -den;
      end else if (shape < 85) begin
         num = $urandom_range(0, 40) - 20;
         den = $urandom_range(0, 40) - 20;
      end else if (shape < 90) begin
         num = $urandom;
         den = '0;
      end else if (shape < 95) begin
         num = corner_value($urandom_range(0, 5));
         den = corner_value($urandom_range(0, 5));
      end else begin
         // Numerator a multiple of the denominator.
         den = $urandom_range(1, 1 << 20);
         num = den * $urandom_range(0, 1000);
         if ($urandom_range(0, 1)) den = -den;
      end
   endtask

   initial begin : stimulus
      logic [WORD_BITS-1:0] num, den;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed fractions: zeros, extremes, sign combinations.
      send_fraction(0, 5);
      send_fraction(0, -7);
      send_fraction(5, 0);
      send_fraction(0, 0);
      send_fraction(MOST_NEG, 0);
      send_fraction(MOST_POS, MOST_POS);
      send_fraction(MOST_POS, MOST_NEG + 1'b1);
      send_fraction(MOST_NEG + 1'b1, 1);
      send_fraction(1, MOST_POS);
      send_fraction(6, 4);
      send_fraction(-6, 4);
      send_fraction(6, -4);
      send_fraction(-6, -4);
      send_fraction(MOST_NEG, 1);
      send_fraction(MOST_NEG, -1);
      send_fraction(1, MOST_NEG);
      send_fraction(MOST_NEG, MOST_NEG);
      send_fraction(MOST_NEG, 6);
      send_fraction(-1, -1);
      send_fraction(MOST_POS, -1);
      send_fraction(2147483646, -1073741823);
      send_fraction(1836311903, 1134903170);
      send_fraction(-1134903170, 1836311903);
      send_fraction(-12, 0);
      wait_drained();

      // Random fractions with a long receiver hold-off and two full drains.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 120 || i == 400) wait_drained();
         if (i == 200) long_hold_req = 1'b1;
         if (i == RANDOM_ITEMS - 80) steady_tail = 1'b1;
         pick_fraction(num, den);
         send_fraction(num, den);
      end

      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.failures == 0) begin
         $display("fraction_reducer regression: pass");
      end else begin
         $display("fraction_reducer regression: fail");
      end
      $finish;
   end

endmodule
